>>> rtl/r256_pkg.sv
// Package for the Rijndael-256 block encryption core.
// Holds the state and column types, the S-box and GF(2^8) helpers; no dependencies.
package r256_pkg;

  localparam int unsigned NB = 8;
  localparam int unsigned BLOCK_BITS = 256;

  typedef logic [7:0] byte_t;
  typedef logic [31:0] col_t;
  typedef logic [BLOCK_BITS-1:0] block_t;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_ENCRYPT = 1'b1;

  function automatic byte_t xtime(input byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t sbox(input byte_t x);
    byte_t t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    sbox = t[x];
  endfunction

endpackage

>>> rtl/r256_if.sv
// Valid/ready channel interfaces for the Rijndael-256 core.
// Depends on nothing; payload fields are plain 64-bit words.
interface r256_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [3:0]  key_index;
  logic [63:0] data_word0;
  logic [63:0] data_word1;
  logic [63:0] data_word2;
  logic [63:0] data_word3;
  modport source (output valid, op, key_index, data_word0, data_word1, data_word2,
                  data_word3, input ready);
  modport sink (input valid, op, key_index, data_word0, data_word1, data_word2,
                data_word3, output ready);
endinterface

interface r256_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] cipher_word0;
  logic [63:0] cipher_word1;
  logic [63:0] cipher_word2;
  logic [63:0] cipher_word3;
  modport source (output valid, cipher_word0, cipher_word1, cipher_word2, cipher_word3,
                  input ready);
  modport sink (input valid, cipher_word0, cipher_word1, cipher_word2, cipher_word3,
                output ready);
endinterface

>>> rtl/r256_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module r256_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/r256_col_cell.sv
// One column cell of the round datapath: SubBytes, MixColumns and key add for a column.
// Depends on r256_pkg for the S-box and xtime.
module r256_col_cell (
  input  logic            clk,
  input  logic            load,
  input  r256_pkg::col_t  load_col,
  input  logic            step,
  input  logic            mix,
  input  r256_pkg::col_t  shifted_col,
  input  r256_pkg::col_t  key_col,
  output r256_pkg::col_t  col_r
);
  r256_pkg::byte_t s [4];
  r256_pkg::byte_t m [4];
  r256_pkg::col_t  col_nxt;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      s[r] = r256_pkg::sbox(shifted_col[8*r +: 8]);
    end
    m[0] = r256_pkg::xtime(s[0]) ^ r256_pkg::xtime(s[1]) ^ s[1] ^ s[2] ^ s[3];
    m[1] = s[0] ^ r256_pkg::xtime(s[1]) ^ r256_pkg::xtime(s[2]) ^ s[2] ^ s[3];
    m[2] = s[0] ^ s[1] ^ r256_pkg::xtime(s[2]) ^ r256_pkg::xtime(s[3]) ^ s[3];
    m[3] = r256_pkg::xtime(s[0]) ^ s[0] ^ s[1] ^ s[2] ^ r256_pkg::xtime(s[3]);
    col_nxt = col_r;
    if (load) begin
      col_nxt = load_col ^ key_col;
    end else if (step) begin
      col_nxt = (mix ? {m[3], m[2], m[1], m[0]} : {s[3], s[2], s[1], s[0]}) ^ key_col;
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
  end
endmodule

>>> rtl/rijndael256_block_encrypt_core.sv
// Top level of the Rijndael-256 block encryption core.
// Depends on r256_pkg, r256_if, r256_ram and r256_col_cell.
//
// Usage:
//   The input channel carries load and encrypt transactions. A load (op 0)
//   writes a 256-bit round key at key_index into the key RAM; indexes above
//   MAX_ROUNDS are dropped. An encrypt (op 1) carries one plaintext block and
//   produces one ciphertext transaction on the output channel.
//   The block works on one encryption at a time. A row of eight column cells
//   holds the state; each round the cells exchange bytes along the ShiftRows
//   pattern and each cell applies SubBytes, MixColumns and AddRoundKey to its
//   column. The key RAM has a registered read, so each round key is read ahead
//   of its use: key 0 is read as the encrypt is taken, FETCH adds it to the
//   plaintext, the first RUN slot fetches key 1, each later RUN step applies
//   one round, and the last leads to DONE and out_valid. A load writes when taken.
//   The ciphertext sits in the cell row and is held while the receiver stalls;
//   a new input is taken in the same cycle the result is taken.
//   round_count is written through cfg_we/cfg_wdata, only while idle; the
//   user must see to that, the block does not enforce it. 0 acts as 1 and
//   values above MAX_ROUNDS act as MAX_ROUNDS. Reset (rst_n low, synchronous)
//   clears the control state, sets round_count to 14; key RAM is undefined until loaded.
module rijndael256_block_encrypt_core #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  r256_in_if.sink     in_ch,
  r256_out_if.source  out_ch
);
  localparam int KEYS = MAX_ROUNDS + 1;
  localparam int KW = $clog2(KEYS);

  typedef enum logic [1:0] {ST_IDLE, ST_FETCH, ST_RUN, ST_DONE} state_t;

  state_t                 state_r;
  logic [3:0]             round_count_r;
  logic [3:0]             round_r;
  logic [3:0]             nr;
  logic                   in_fire;
  logic                   load_st;
  logic                   step;
  logic [KW-1:0]          raddr;
  r256_pkg::block_t       key_blk;
  r256_pkg::block_t       pt_r;
  r256_pkg::block_t       in_blk;
  r256_pkg::col_t         cols [r256_pkg::NB];
  r256_pkg::col_t         shifted [r256_pkg::NB];

  assign nr = (round_count_r == 4'd0) ? 4'd1 :
              (round_count_r > 4'(MAX_ROUNDS)) ? 4'(MAX_ROUNDS) : round_count_r;

  assign in_ch.ready = (state_r == ST_IDLE) || (state_r == ST_DONE && out_ch.ready);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign in_blk = {in_ch.data_word3, in_ch.data_word2, in_ch.data_word1, in_ch.data_word0};

  // The RAM reads the key for the round after the current one. In the last
  // round there is no next key, so the address falls back to key 0.
  assign raddr = (state_r == ST_RUN && round_r != nr) ? KW'(round_r + 4'd1) : '0;

  r256_ram #(.WIDTH(256), .DEPTH(KEYS)) u_keys (
    .clk(clk),
    .we(in_fire && in_ch.op == r256_pkg::OP_LOAD && in_ch.key_index <= 4'(MAX_ROUNDS)),
    .waddr(KW'(in_ch.key_index)),
    .wdata(in_blk),
    .raddr(raddr),
    .rdata(key_blk)
  );

  assign load_st = (state_r == ST_FETCH);
  assign step = (state_r == ST_RUN) && (round_r != 4'd0);

  // ShiftRows wiring: row r of column c comes from column c + offset.
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      shifted[c][7:0]   = cols[c][7:0];
      shifted[c][15:8]  = cols[(c + 1) % 8][15:8];
      shifted[c][23:16] = cols[(c + 3) % 8][23:16];
      shifted[c][31:24] = cols[(c + 4) % 8][31:24];
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_cell
    r256_col_cell u_cell (
      .clk(clk),
      .load(load_st),
      .load_col(pt_r[32*c +: 32]),
      .step(step),
      .mix(round_r != nr),
      .shifted_col(shifted[c]),
      .key_col(key_blk[32*c +: 32]),
      .col_r(cols[c])
    );
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pt_r <= in_blk;
    end
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      round_count_r <= 4'd14;
      round_r       <= 4'd0;
    end else begin
      if (cfg_we) begin
        round_count_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE, ST_DONE: begin
          if (state_r == ST_DONE && out_ch.ready) begin
            state_r <= ST_IDLE;
          end
          if (in_fire && in_ch.op == r256_pkg::OP_ENCRYPT) begin
            state_r <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          state_r <= ST_RUN;
          round_r <= 4'd0;
        end
        ST_RUN: begin
          if (round_r == nr) begin
            state_r <= ST_DONE;
          end else begin
            round_r <= round_r + 4'd1;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // round_r == 0 in ST_RUN is the fetch slot of key 1; the cells already hold
  // plaintext xor key 0 from the FETCH cycle.
  assign out_ch.valid = (state_r == ST_DONE);
  assign out_ch.cipher_word0 = {cols[1], cols[0]};
  assign out_ch.cipher_word1 = {cols[3], cols[2]};
  assign out_ch.cipher_word2 = {cols[5], cols[4]};
  assign out_ch.cipher_word3 = {cols[7], cols[6]};

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.cipher_word0))
    else $error("result changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FETCH || state_r == ST_RUN) |-> !in_ch.ready)
    else $error("input taken while busy");
  a_round: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> round_r <= nr)
    else $error("round counter overran");
endmodule

>>> tb/r256_checker.sv
// Checker for the Rijndael-256 encryption core: watches both channels and the config port.
// It predicts every ciphertext and compares it field by field. Depends on r256_pkg and r256_if.
`timescale 1ns / 1ps

module r256_checker #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  r256_in_if          in_mon,
  r256_out_if         out_mon,
  output int          errors,
  output int          pending
);

  r256_pkg::byte_t   sub_table [256];
  r256_pkg::block_t  key_store [MAX_ROUNDS+1];
  logic [3:0] rounds_reg;
  r256_pkg::block_t  cipher_q [$];

  function automatic r256_pkg::byte_t gmul(input r256_pkg::byte_t a,
                                           input r256_pkg::byte_t b);
    r256_pkg::byte_t p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[0]) p ^= a;
      a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
      b = b >> 1;
    end
    return p;
  endfunction

  // Inverse as x^254, then the affine map.
  function automatic r256_pkg::byte_t sub_calc(input r256_pkg::byte_t x);
    r256_pkg::byte_t r, base, y;
    int e;
    r = 8'h01;
    base = x;
    e = 254;
    while (e != 0) begin
      if (e & 1) r = gmul(r, base);
      base = gmul(base, base);
      e = e >> 1;
    end
    if (x == 8'h00) r = 8'h00;
    y = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]} ^ {r[3:0], r[7:4]} ^ 8'h63;
    return y;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) sub_table[i] = sub_calc(r256_pkg::byte_t'(i));
  end

  function automatic r256_pkg::block_t encrypt_block(input r256_pkg::block_t pt,
                                                     input logic [3:0] rc);
    r256_pkg::byte_t s [32];
    r256_pkg::byte_t t [32];
    r256_pkg::byte_t a0, a1, a2, a3;
    int nr;
    int shift [4];
    r256_pkg::block_t ct;
    shift = '{0, 1, 3, 4};
    nr = (rc == 0) ? 1 : ((rc > MAX_ROUNDS) ? MAX_ROUNDS : rc);
    for (int k = 0; k < 32; k++) s[k] = pt[8*k +: 8] ^ key_store[0][8*k +: 8];
    for (int rnd = 1; rnd <= nr; rnd++) begin
      for (int c = 0; c < 8; c++)
        for (int r = 0; r < 4; r++)
          t[4*c+r] = sub_table[s[4*((c + shift[r]) % 8) + r]];
      if (rnd < nr) begin
        for (int c = 0; c < 8; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          t[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
          t[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
          t[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
          t[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
        end
      end
      for (int k = 0; k < 32; k++) s[k] = t[k] ^ key_store[rnd][8*k +: 8];
    end
    for (int k = 0; k < 32; k++) ct[8*k +: 8] = s[k];
    return ct;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  initial errors = 0;
  assign pending = cipher_q.size();

  always @(posedge clk) begin
    r256_pkg::block_t want;
    r256_pkg::block_t pt;
    if (!rst_n) begin
      rounds_reg <= 4'd14;
    end else begin
      if (cfg_we) rounds_reg <= cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        pt = {in_mon.data_word3, in_mon.data_word2, in_mon.data_word1, in_mon.data_word0};
        if (in_mon.op == r256_pkg::OP_ENCRYPT) begin
          cipher_q.push_back(encrypt_block(pt, rounds_reg));
        end else if (in_mon.key_index <= MAX_ROUNDS) begin
          key_store[in_mon.key_index] = pt;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (cipher_q.size() == 0) begin
          $display("unexpected ciphertext transaction at %0t", $realtime);
          errors++;
        end else begin
          want = cipher_q.pop_front();
          if (out_mon.cipher_word0 !== want[63:0])
            report_mismatch("cipher_word0", out_mon.cipher_word0, want[63:0]);
          if (out_mon.cipher_word1 !== want[127:64])
            report_mismatch("cipher_word1", out_mon.cipher_word1, want[127:64]);
          if (out_mon.cipher_word2 !== want[191:128])
            report_mismatch("cipher_word2", out_mon.cipher_word2, want[191:128]);
          if (out_mon.cipher_word3 !== want[255:192])
            report_mismatch("cipher_word3", out_mon.cipher_word3, want[255:192]);
        end
      end
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the Rijndael-256 core testbench: clock, reset, stimulus and verdict.
// Depends on r256_pkg, r256_if, the core and r256_checker, which does all prediction.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_ROUNDS = 14;
  localparam int CYCLE_LIMIT = 600000;
  // Margin after the last result is taken; it covers the tail of a load too.
  localparam int DRAIN_CYCLES = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_wdata = 4'd0;
  int errors;
  int pending;
  int cycles = 0;
  int n_encrypt = 0;
  int n_load = 0;
  int n_phase = 0;
  bit burst_mode = 1'b0;
  int out_stall = 0;

  r256_in_if  in_ch();
  r256_out_if out_ch();

  rijndael256_block_encrypt_core #(.MAX_ROUNDS(MAX_ROUNDS)) dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  r256_checker #(.MAX_ROUNDS(MAX_ROUNDS)) chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_mon(in_ch), .out_mon(out_ch), .errors(errors), .pending(pending)
  );

  always #10 clk = ~clk;

  // The run is bounded so a hung handshake still ends with a verdict.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = r256_pkg::OP_LOAD;
    in_ch.key_index = 4'd0;
    in_ch.data_word0 = '0;
    in_ch.data_word1 = '0;
    in_ch.data_word2 = '0;
    in_ch.data_word3 = '0;
    out_ch.ready = 1'b0;
  end

  // After a ciphertext transaction the receiver mostly draws a stall length; in
  // burst stretches, and at random now and then, it takes results at once.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      if (burst_mode || $urandom_range(19, 0) == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        out_stall <= $urandom_range(19, 1);
      end
    end else if (!out_ch.ready) begin
      if (out_stall <= 1) out_ch.ready <= 1'b1;
      else out_stall <= out_stall - 1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // One transaction on the input channel. Valid is lowered only when a gap
  // follows, so back-to-back transactions keep it high across the edge.
  task automatic send_item(input logic op, input logic [3:0] idx,
                           input r256_pkg::block_t data);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(19, 0);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.key_index <= idx;
    in_ch.data_word0 <= data[63:0];
    in_ch.data_word1 <= data[127:64];
    in_ch.data_word2 <= data[191:128];
    in_ch.data_word3 <= data[255:192];
    do @(posedge clk); while (!in_ch.ready);
    if (op == r256_pkg::OP_ENCRYPT) n_encrypt++;
    else n_load++;
  endtask

  task automatic load_key(input logic [3:0] idx, input r256_pkg::block_t key_val);
    send_item(r256_pkg::OP_LOAD, idx, key_val);
  endtask

  task automatic encrypt(input r256_pkg::block_t pt);
    send_item(r256_pkg::OP_ENCRYPT, 4'd0, pt);
  endtask

  function automatic r256_pkg::block_t rand_block();
    return {rand64(), rand64(), rand64(), rand64()};
  endfunction

  // Drain the pipeline completely and then write the round count.
  task automatic set_rounds(input logic [3:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_phase++;
  endtask

  initial begin
    logic [3:0] phase_rounds [8];
    logic [3:0] idx;
    phase_rounds = '{4'd14, 4'd1, 4'd0, 4'd15, 4'd10, 4'd2, 4'd13, 4'd7};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every round key gets written before any encryption so that
    // no unwritten key is ever read. Keys use all-zero and all-one extremes.
    for (int i = 0; i <= MAX_ROUNDS; i++)
      load_key(i[3:0], (i % 2 == 0) ? {256{1'b1}} : rand_block());
    // An index above the store is dropped and must not disturb key 0.
    load_key(4'd15, '0);
    encrypt('0);
    encrypt({256{1'b1}});
    encrypt(rand_block());
    load_key(4'd0, '0);
    encrypt({256{1'b1}});
    encrypt({4{64'h0123456789abcdef}});

    // Random part: phases at several round counts, extremes and out-of-range
    // values among them. Mostly encryptions with a few key reloads in between.
    for (int p = 0; p < 8; p++) begin
      set_rounds(phase_rounds[p]);
      for (int n = 0; n < 105; n++) begin
        if (n % 35 == 0) burst_mode = ($urandom_range(2, 0) == 0);
        if ($urandom_range(9, 0) == 0) begin
          idx = 4'($urandom_range(15, 0));
          load_key(idx, rand_block());
        end else begin
          encrypt(rand_block());
        end
      end
      burst_mode = 1'b0;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d encryptions and %0d key loads over %0d round count settings",
             n_encrypt, n_load, n_phase);
    $display("mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/r256_pkg.sv
rtl/r256_if.sv
rtl/r256_ram.sv
rtl/r256_col_cell.sv
rtl/rijndael256_block_encrypt_core.sv
tb/r256_checker.sv
tb/testbench.sv
